[rtl/mrukv_pkg.sv]
// Shared types and constants for the MRU key-value cache.
// Used by mrukv_ctrl, mrukv_dp and the top level; depends on nothing.
package mrukv_pkg;

    localparam int MRUKV_ENTRIES   = 16;
    localparam int MRUKV_KEY_W     = 32;
    localparam int MRUKV_VAL_W     = 32;
    localparam int MRUKV_CAP_W     = 5;
    localparam logic [MRUKV_CAP_W-1:0] MRUKV_CAP_RESET = 5'd16;

    localparam logic MRUKV_OP_GET = 1'b0;
    localparam logic MRUKV_OP_PUT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FETCH,
        ST_RESOLVE
    } mrukv_state_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic resolve;
    } mrukv_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic out_free;
    } mrukv_status_t;

endpackage

[rtl/mrukv_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Standalone; used for the key and value stores.
module mrukv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/mrukv_ctrl.sv]
// Request sequencer of the MRU key-value cache.
// Depends on mrukv_pkg; drives the datapath through mrukv_cmd_t.
module mrukv_ctrl
    import mrukv_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  mrukv_status_t status,
    output mrukv_cmd_t    cmd
);

    mrukv_state_t state_reg;
    mrukv_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        s_tready    = 1'b0;
        cmd         = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (status.scan_done) begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH: begin
                state_next = ST_RESOLVE;
            end
            ST_RESOLVE: begin
                if (status.out_free) begin
                    cmd.resolve = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/mrukv_dp.sv]
// Datapath of the MRU key-value cache: request registers, key scan,
// key and value stores, fill and MRU tracking, and the result register.
// Depends on mrukv_pkg and mrukv_ram.
module mrukv_dp
    import mrukv_pkg::*;
#(
    parameter int ENTRIES = MRUKV_ENTRIES
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  mrukv_cmd_t             cmd,
    output mrukv_status_t          status,
    input  logic                   cfg_wr_en,
    input  logic [MRUKV_CAP_W-1:0] cfg_wr_data,
    input  logic                   req_op,
    input  logic [MRUKV_KEY_W-1:0] req_key,
    input  logic [MRUKV_VAL_W-1:0] req_value,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [63:0]            m_tdata,
    output logic [1:0]             m_tuser
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int EW = (CW > MRUKV_CAP_W) ? CW : MRUKV_CAP_W;

    logic                          op_reg;
    logic signed [MRUKV_KEY_W-1:0] key_reg;
    logic signed [MRUKV_VAL_W-1:0] value_reg;
    logic [CW-1:0]                 scan_idx_reg;
    logic [IW-1:0]                 cmp_idx_reg;
    logic                          cmp_valid_reg;
    logic                          found_reg;
    logic [IW-1:0]                 slot_reg;
    logic [CW-1:0]                 fill_reg;
    logic [IW-1:0]                 mru_reg;
    logic [MRUKV_CAP_W-1:0]        cap_reg;

    logic                          out_valid_reg;
    logic                          out_hit_reg;
    logic                          out_evicted_reg;
    logic signed [MRUKV_VAL_W-1:0] out_read_value_reg;
    logic signed [MRUKV_KEY_W-1:0] out_evicted_key_reg;

    logic [MRUKV_KEY_W-1:0] key_rdata;
    logic [MRUKV_VAL_W-1:0] val_rdata;
    logic [IW-1:0]          key_raddr;
    logic                   issue;
    logic                   match_now;

    logic [EW-1:0]                 cap_eff;
    logic                          full;
    logic                          key_we;
    logic                          val_we;
    logic [IW-1:0]                 wr_slot;
    logic                          hit_next;
    logic                          evicted_next;
    logic signed [MRUKV_VAL_W-1:0] read_value_next;
    logic signed [MRUKV_KEY_W-1:0] evicted_key_next;
    logic [CW-1:0]                 fill_next;
    logic [IW-1:0]                 mru_next;

    assign match_now = cmp_valid_reg && (key_rdata == key_reg);
    assign issue     = cmd.scan && (scan_idx_reg < fill_reg) && !match_now;
    assign key_raddr = cmd.scan ? scan_idx_reg[IW-1:0] : mru_reg;

    assign status.scan_done = match_now || (scan_idx_reg >= fill_reg);
    assign status.out_free  = !out_valid_reg || m_tready;

    always_comb begin
        if (cap_reg == '0) begin
            cap_eff = EW'(1);
        end else if (EW'(cap_reg) > EW'(ENTRIES)) begin
            cap_eff = EW'(ENTRIES);
        end else begin
            cap_eff = EW'(cap_reg);
        end
    end

    assign full = EW'(fill_reg) >= cap_eff;

    always_comb begin
        key_we           = 1'b0;
        val_we           = 1'b0;
        wr_slot          = slot_reg;
        hit_next         = found_reg;
        evicted_next     = 1'b0;
        read_value_next  = '0;
        evicted_key_next = '0;
        fill_next        = fill_reg;
        mru_next         = mru_reg;
        if (op_reg == MRUKV_OP_GET) begin
            if (found_reg) begin
                read_value_next = val_rdata;
                mru_next        = slot_reg;
            end else begin
                read_value_next = '1;
            end
        end else if (found_reg) begin
            val_we   = 1'b1;
            mru_next = slot_reg;
        end else begin
            key_we = 1'b1;
            val_we = 1'b1;
            if (full) begin
                wr_slot          = mru_reg;
                evicted_next     = 1'b1;
                evicted_key_next = key_rdata;
            end else begin
                wr_slot   = fill_reg[IW-1:0];
                fill_next = fill_reg + CW'(1);
            end
            mru_next = wr_slot;
        end
    end

    mrukv_ram #(
        .WIDTH(MRUKV_KEY_W),
        .DEPTH(ENTRIES)
    ) u_key_ram (
        .aclk (aclk),
        .we   (cmd.resolve && key_we),
        .waddr(wr_slot),
        .wdata(key_reg),
        .raddr(key_raddr),
        .rdata(key_rdata)
    );

    mrukv_ram #(
        .WIDTH(MRUKV_VAL_W),
        .DEPTH(ENTRIES)
    ) u_val_ram (
        .aclk (aclk),
        .we   (cmd.resolve && val_we),
        .waddr(wr_slot),
        .wdata(value_reg),
        .raddr(slot_reg),
        .rdata(val_rdata)
    );

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg        <= req_op;
            key_reg       <= req_key;
            value_reg     <= req_value;
            scan_idx_reg  <= '0;
            cmp_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            slot_reg      <= '0;
        end else if (cmd.scan) begin
            cmp_valid_reg <= issue;
            cmp_idx_reg   <= scan_idx_reg[IW-1:0];
            if (issue) begin
                scan_idx_reg <= scan_idx_reg + CW'(1);
            end
            if (match_now) begin
                found_reg <= 1'b1;
                slot_reg  <= cmp_idx_reg;
            end
        end
        if (cmd.resolve) begin
            out_hit_reg         <= hit_next;
            out_evicted_reg     <= evicted_next;
            out_read_value_reg  <= read_value_next;
            out_evicted_key_reg <= evicted_key_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg      <= '0;
            mru_reg       <= '0;
            cap_reg       <= MRUKV_CAP_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
            if (cmd.resolve) begin
                fill_reg      <= fill_next;
                mru_reg       <= mru_next;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_evicted_key_reg, out_read_value_reg};
    assign m_tuser  = {out_evicted_reg, out_hit_reg};

    a_fill_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        EW'(fill_reg) <= EW'(ENTRIES))
        else $error("fill count exceeds the number of slots");

    a_fill_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> (fill_reg == $past(fill_reg))
                        || (fill_reg == $past(fill_reg) + CW'(1)))
        else $error("fill count changed by more than one");

    a_get_no_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.resolve && op_reg == MRUKV_OP_GET) |=> !out_evicted_reg)
        else $error("get request reported an eviction");

    a_evict_only_on_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> !(out_evicted_reg && out_hit_reg))
        else $error("eviction reported on a hit");

endmodule

[rtl/mru_replacement_kv_cache_unit.sv]
// Top level of the MRU key-value cache: sequencer plus datapath.
// Depends on mrukv_pkg, mrukv_ctrl, mrukv_dp and mrukv_ram.
//
// A store of up to min(capacity, ENTRIES) key-value pairs (a capacity of 0 counts
// as 1) with most-recently-used replacement. Each request is a get or a put; each
// gives exactly one response. A request is handled one at a time: it is accepted,
// the occupied slots of the key store are scanned through its single read port
// with a registered compare, the value is fetched, and the request is resolved;
// a hit ends the scan early. The resolve step waits while the previous response
// still sits unread in the output register.
// A finished response waits in the output register while the next request is
// accepted. The capacity register may be written only while no request is open.
module mru_replacement_kv_cache_unit
    import mrukv_pkg::*;
#(
    parameter int ENTRIES = MRUKV_ENTRIES
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [MRUKV_CAP_W-1:0] cfg_wr_data,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [63:0]            s_tdata,   // key [31:0], value [63:32]
    input  logic [0:0]             s_tuser,   // op [0]
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [63:0]            m_tdata,   // read_value [31:0], evicted_key [63:32]
    output logic [1:0]             m_tuser    // hit [0], evicted [1]
);

    mrukv_cmd_t    cmd;
    mrukv_status_t status;

    mrukv_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .status  (status),
        .cmd     (cmd)
    );

    mrukv_dp #(
        .ENTRIES(ENTRIES)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .status     (status),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .req_op     (s_tuser[0]),
        .req_key    (s_tdata[31:0]),
        .req_value  (s_tdata[63:32]),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule
